@@ design/soc_pkg.sv @@
// shared types and constants for the substring occurrence counter
package soc_pkg;

    localparam int MAX_NEEDLE_DEF = 16;
    localparam int COUNT_BITS_DEF = 32;
    localparam int NEEDLE_BYTES   = 16;
    localparam int QUEUE_DEPTH    = 4;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NEEDLE_LO  = 2'd0,
        CFG_NEEDLE_HI  = 2'd1,
        CFG_NEEDLE_LEN = 2'd2,
        CFG_LIMIT      = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic end_item;
        logic count_hit;
        logic short_hay;
    } item_t;

endpackage

@@ design/soc_front.sv @@
// front end: configuration, byte window, needle compare and item classification
module soc_front #(
    parameter int MAX_NEEDLE = soc_pkg::MAX_NEEDLE_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [soc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [soc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,
    input  logic                          s_tlast,
    output logic                          push_valid,
    input  logic                          push_ready,
    output soc_pkg::item_t                push_item
);

    localparam int LEN_W = $clog2(MAX_NEEDLE + 1);

    logic [63:0]      needle_lo_reg;
    logic [63:0]      needle_hi_reg;
    logic [4:0]       pat_len_reg;
    logic [31:0]      limit_reg;
    logic [7:0]       win_reg  [MAX_NEEDLE];
    logic [7:0]       win_next [MAX_NEEDLE];
    logic [31:0]      pos_reg;
    logic [31:0]      pos_next;
    logic             lim_hit_reg;
    logic             lim_hit_next;
    logic [7:0]       needle_b [soc_pkg::NEEDLE_BYTES];
    logic [LEN_W-1:0] eff_len;
    logic [31:0]      len32;
    logic [MAX_NEEDLE-1:0] lane_ok;
    logic             match;
    logic             full_win;
    logic             past_bound;
    logic             accept;

    assign cfg_ready  = 1'b1;
    assign s_tready   = push_ready;
    assign push_valid = s_tvalid;
    assign accept     = s_tvalid && push_ready;

    always_comb begin
        int k_len;
        k_len = int'(pat_len_reg);
        if (k_len == 0) begin
            k_len = 1;
        end else if (k_len > MAX_NEEDLE) begin
            k_len = MAX_NEEDLE;
        end
        eff_len = LEN_W'(k_len);
    end

    assign len32 = 32'(eff_len);

    always_comb begin
        for (int k = 0; k < soc_pkg::NEEDLE_BYTES; k++) begin
            if (k < 8) begin
                needle_b[k] = needle_lo_reg[8*k +: 8];
            end else begin
                needle_b[k] = needle_hi_reg[8*(k-8) +: 8];
            end
        end
    end

    always_comb begin
        win_next[0] = s_tdata;
        for (int j = 1; j < MAX_NEEDLE; j++) begin
            win_next[j] = win_reg[j-1];
        end
    end

    // lane j holds needle byte len-1-j
    always_comb begin
        logic [7:0] sel_byte;
        for (int j = 0; j < MAX_NEEDLE; j++) begin
            sel_byte = 8'h00;
            for (int k = 0; k < soc_pkg::NEEDLE_BYTES; k++) begin
                if (k + j + 1 == int'(eff_len)) begin
                    sel_byte = needle_b[k];
                end
            end
            lane_ok[j] = (j >= int'(eff_len)) || (win_next[j] == sel_byte);
        end
    end

    assign match        = &lane_ok;
    assign pos_next     = (pos_reg == '1) ? pos_reg : pos_reg + 32'd1;
    assign full_win     = pos_next >= len32;
    assign past_bound   = (limit_reg >= len32) ? (pos_next > limit_reg) : (pos_next > len32);
    assign lim_hit_next = lim_hit_reg || (full_win && past_bound);

    always_comb begin
        push_item.end_item  = s_tlast;
        push_item.count_hit = full_win && match && !lim_hit_next;
        push_item.short_hay = pos_reg < len32;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            needle_lo_reg  <= '0;
            needle_hi_reg  <= '0;
            pat_len_reg    <= 5'd1;
            limit_reg      <= '1;
            pos_reg        <= '0;
            lim_hit_reg    <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    soc_pkg::CFG_NEEDLE_LO:  needle_lo_reg  <= cfg_data;
                    soc_pkg::CFG_NEEDLE_HI:  needle_hi_reg  <= cfg_data;
                    soc_pkg::CFG_NEEDLE_LEN: pat_len_reg    <= cfg_data[4:0];
                    soc_pkg::CFG_LIMIT:      limit_reg      <= cfg_data[31:0];
                    default: ;
                endcase
            end
            if (accept) begin
                if (s_tlast) begin
                    pos_reg     <= '0;
                    lim_hit_reg <= 1'b0;
                end else begin
                    pos_reg     <= pos_next;
                    lim_hit_reg <= lim_hit_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && !s_tlast) begin
            win_reg <= win_next;
        end
    end

endmodule

@@ design/soc_queue.sv @@
// short item queue between front end and back end
module soc_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  soc_pkg::item_t push_item,
    output logic           pop_valid,
    input  logic           pop_ready,
    output soc_pkg::item_t pop_item
);

    localparam int PTR_W  = $clog2(soc_pkg::QUEUE_DEPTH);
    localparam int FILL_W = $clog2(soc_pkg::QUEUE_DEPTH + 1);

    soc_pkg::item_t    slot_reg [soc_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = fill_reg != FILL_W'(soc_pkg::QUEUE_DEPTH);
    assign pop_valid  = fill_reg != '0;
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    assign wr_ptr_next = (wr_ptr_reg == PTR_W'(soc_pkg::QUEUE_DEPTH - 1))
                         ? '0 : wr_ptr_reg + PTR_W'(1);
    assign rd_ptr_next = (rd_ptr_reg == PTR_W'(soc_pkg::QUEUE_DEPTH - 1))
                         ? '0 : rd_ptr_reg + PTR_W'(1);

    always_comb begin
        fill_next = fill_reg;
        if (do_push && !do_pop) begin
            fill_next = fill_reg + FILL_W'(1);
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - FILL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_next;
            end
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ design/soc_back.sv @@
// back end: occurrence counter and result output register
module soc_back #(
    parameter int COUNT_BITS = soc_pkg::COUNT_BITS_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           pop_valid,
    output logic           pop_ready,
    input  soc_pkg::item_t pop_item,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [31:0]    m_tdata,
    output logic [0:0]     m_tuser
);

    logic [COUNT_BITS-1:0] occ_reg;
    logic                  m_tvalid_reg;
    logic [31:0]           count_out_reg;
    logic                  nf_reg;
    logic                  out_free;
    logic                  take;
    logic                  take_end;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign pop_ready = !pop_item.end_item || out_free;
    assign take      = pop_valid && pop_ready;
    assign take_end  = take && pop_item.end_item;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = count_out_reg;
    assign m_tuser  = nf_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (take_end) begin
                occ_reg <= '0;
            end else if (take && pop_item.count_hit && (occ_reg != '1)) begin
                occ_reg <= occ_reg + COUNT_BITS'(1);
            end
            if (take_end) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take_end) begin
            count_out_reg <= pop_item.short_hay ? 32'd0 : 32'(occ_reg);
            nf_reg        <= pop_item.short_hay;
        end
    end

endmodule

@@ design/substring_occurrence_counter_top.sv @@
// top level of the overlapping substring occurrence counter
// accepts one item per cycle while the queue has room; byte items give no result
// an end item is written into a queue slot, then taken by the back end into the result output register
// latency grows while the result port stalls; the 4-entry queue absorbs short stalls
// aresetn is synchronous, active low: clears configuration to defaults, counters,
// queue and output; no clearing pass, the block is ready right after reset
module substring_occurrence_counter_top #(
    parameter int MAX_NEEDLE = soc_pkg::MAX_NEEDLE_DEF,
    parameter int COUNT_BITS = soc_pkg::COUNT_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [soc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [soc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // data_byte
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [31:0]                    m_tdata,   // match_count
    output logic [0:0]                     m_tuser    // not_found
);

    logic           push_valid;
    logic           push_ready;
    soc_pkg::item_t push_item;
    logic           pop_valid;
    logic           pop_ready;
    soc_pkg::item_t pop_item;

    soc_front #(
        .MAX_NEEDLE (MAX_NEEDLE)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    soc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    soc_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

@@ design/soc_checker.sv @@
// port-level checks for the substring occurrence counter, bound to the top level
module soc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        cfg_ready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [0:0]  m_tuser
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // short haystack reports a zero count
    a_nf_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == 32'd0)
        else $error("not_found with nonzero count");

    // no result and a ready input port right after reset
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("state not cleared by reset");

    // configuration never stalls
    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> cfg_ready)
        else $error("configuration port stalled");

endmodule

bind substring_occurrence_counter_top soc_checker u_soc_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tready  (s_tready),
    .cfg_ready (cfg_ready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
);
